>>> rtl/float32_add_sub_truncating_unit_macros.svh
// Assertion macros for the float32 add/sub unit.
`ifndef FLOAT32_ADD_SUB_TRUNCATING_UNIT_MACROS_SVH
`define FLOAT32_ADD_SUB_TRUNCATING_UNIT_MACROS_SVH
`ifndef SYNTH
`define FAS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define FAS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define FAS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define FAS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/fas_pkg.sv
`default_nettype none
package fas_pkg;
    localparam int FRAC_BITS = 23;
    localparam logic [7:0] EXP_MAX = 8'hFF;

    // Classified operation handed from the front to the back.
    typedef struct packed {
        logic        sign;
        logic        same_sign;
        logic        zero_sign;
        logic [7:0]  exp;
        logic [23:0] m1;
        logic [23:0] m2;
    } fas_op_t;
endpackage
`default_nettype wire

>>> rtl/float32_add_sub_truncating_unit.sv
`default_nettype none
// Single-precision add/subtract with truncation (no rounding). One operation
// can be pushed every cycle while full is low; the front aligns the operands
// and places them in a two-entry queue, and the back finishes the sum,
// normalizes it and places the result in a two-entry output queue. A result
// passes through the first queue, then the output queue, before it is visible.
// NaN and infinity inputs are not special-cased, an exponent of 255 or more
// becomes infinity, and underflow flushes to a signed zero. Each beat on either
// side is independent: the unit holds no state beyond the queued items.
module float32_add_sub_truncating_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [31:0] lhs,
    input  wire logic [31:0] rhs,
    input  wire logic        opcode,
    output logic             empty,
    input  wire logic        pop,
    output logic [31:0]      result
);
    import fas_pkg::*;

    fas_op_t     op_in, op_q;
    logic        mid_empty, out_full;
    logic [31:0] res_c;

    fas_front u_front (
        .lhs    (lhs),
        .rhs    (rhs),
        .opcode (opcode),
        .op     (op_in)
    );

    fas_queue #(.W($bits(fas_op_t))) u_mid (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (push),
        .wdata (op_in),
        .full  (full),
        .rd    (!out_full),
        .rdata (op_q),
        .empty (mid_empty)
    );

    fas_back u_back (
        .op     (op_q),
        .result (res_c)
    );

    fas_queue #(.W(32)) u_out (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (!mid_empty),
        .wdata (res_c),
        .full  (out_full),
        .rd    (pop),
        .rdata (result),
        .empty (empty)
    );
endmodule
`default_nettype wire

>>> rtl/fas_front.sv
`default_nettype none
module fas_front (
    input  wire logic [31:0]     lhs,
    input  wire logic [31:0]     rhs,
    input  wire logic            opcode,
    output fas_pkg::fas_op_t     op
);
    import fas_pkg::*;

    logic        sa, sb, swap, s1, s2;
    logic [7:0]  ea, eb, e1, e2, diff;
    logic [22:0] fa, fb, f1, f2;
    logic [23:0] m2_full;

    always_comb
    begin
        sa = lhs[31];
        sb = rhs[31] ^ opcode;
        ea = lhs[30:23];
        eb = rhs[30:23];
        fa = lhs[22:0];
        fb = rhs[22:0];
        swap = (ea < eb) || ((ea == eb) && (fa < fb));
        s1 = swap ? sb : sa;
        s2 = swap ? sa : sb;
        e1 = swap ? eb : ea;
        e2 = swap ? ea : eb;
        f1 = swap ? fb : fa;
        f2 = swap ? fa : fb;
        diff = e1 - e2;
        m2_full = {(e2 != 8'd0), f2};
        op.sign = s1;
        op.same_sign = (s1 == s2);
        op.zero_sign = s1 & s2;
        op.exp = e1;
        op.m1 = {(e1 != 8'd0), f1};
        // A shift of 24 or more already clears a 24-bit significand.
        op.m2 = (diff >= 8'd24) ? 24'd0 : (m2_full >> diff[4:0]);
    end
endmodule
`default_nettype wire

>>> rtl/fas_queue.sv
`default_nettype none
`include "float32_add_sub_truncating_unit_macros.svh"
module fas_queue #(
    parameter int W = 8
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         wr,
    input  wire logic [W-1:0] wdata,
    output logic              full,
    input  wire logic         rd,
    output logic [W-1:0]      rdata,
    output logic              empty
);
    // Two-entry queue; full and empty come straight from registers.
    logic [W-1:0] mem_reg [2];
    logic         wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0]   cnt_reg, cnt_next;
    logic         do_wr, do_rd;

    assign do_wr = wr && !full;
    assign do_rd = rd && !empty;
    assign full  = cnt_reg == 2'd2;
    assign empty = cnt_reg == 2'd0;
    assign rdata = mem_reg[rp_reg];

    always_comb
    begin
        wp_next  = wp_reg ^ do_wr;
        rp_next  = rp_reg ^ do_rd;
        cnt_next = cnt_reg + {1'b0, do_wr} - {1'b0, do_rd};
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wp_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    `FAS_ASSERT_IMPL(a_cnt_range, clk, rst_n, 1'b1, cnt_reg != 2'd3)
    `FAS_ASSERT_NEXT(a_fill, clk, rst_n, do_wr && !do_rd, !empty)
    `FAS_ASSERT_NEXT(a_drain, clk, rst_n, do_rd && !do_wr, !full)
endmodule
`default_nettype wire

>>> rtl/fas_back.sv
`default_nettype none
module fas_back (
    input  wire fas_pkg::fas_op_t op,
    output logic [31:0]           result
);
    import fas_pkg::*;

    logic [24:0] mag;
    logic [4:0]  lz;
    logic [23:0] norm;
    logic [9:0]  exp_n;

    always_comb
    begin
        mag = op.same_sign ? ({1'b0, op.m1} + {1'b0, op.m2})
                           : ({1'b0, op.m1} - {1'b0, op.m2});
        lz = 5'd23;
        for (int i = 0; i < 24; i++)
        begin
            if (mag[i])
            begin
                lz = 5'(23 - i);
            end
        end
        if (mag[24])
        begin
            norm  = mag[24:1];
            exp_n = {2'b00, op.exp} + 10'd1;
        end
        else
        begin
            norm  = mag[23:0] << lz;
            exp_n = {2'b00, op.exp} - {5'd0, lz};
        end
        if (mag == 25'd0)
        begin
            result = {op.zero_sign, 31'd0};
        end
        else if (exp_n[9] || exp_n == 10'd0)
        begin
            result = {op.sign, 31'd0};
        end
        else if (exp_n >= 10'd255)
        begin
            result = {op.sign, EXP_MAX, 23'd0};
        end
        else
        begin
            result = {op.sign, exp_n[7:0], norm[FRAC_BITS-1:0]};
        end
    end
endmodule
`default_nettype wire
